>>> rtl/cpid_pkg.sv
// Shared types, constants and helpers for the cooler PID regulator.
package cpid_pkg;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int TEMP_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int INTEG_W    = 40;
  localparam int PWM_W      = 8;

  // Shared multiplier and divider widths
  localparam int MUL_A_W    = 41;
  localparam int MUL_B_W    = 19;
  localparam int PROD_W     = 60;
  localparam int DIV_N_W    = 36;
  localparam int DIV_D_W    = 32;

  // Parameter defaults
  localparam int DEF_HISTORY_DEPTH   = 8;
  localparam int DEF_MAX_RAMP_POINTS = 512;
  localparam int DEF_TEMP_FRAC       = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AOFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PPD  = 3'd7;

  // Register reset values
  localparam logic [15:0] KP_RST   = 16'd3840;
  localparam logic [15:0] KI_RST   = 16'd256;
  localparam logic [17:0] KD_RST   = 18'd102400;
  localparam logic [15:0] KFF_RST  = 16'd1460;
  localparam logic [15:0] AOFF_RST = 16'd768;
  localparam logic [15:0] TRIG_RST = 16'd1024;
  localparam logic [7:0]  STEP_RST = 8'd16;
  localparam logic [15:0] PPD_RST  = 16'd480;

  // Integral saturation bounds
  localparam logic signed [PROD_W-1:0] INTEG_MAX = (60'sd1 <<< (INTEG_W - 1)) - 60'sd1;
  localparam logic signed [PROD_W-1:0] INTEG_MIN = -(60'sd1 <<< (INTEG_W - 1));
  localparam logic signed [PROD_W-1:0] PWM_MAX   = 60'sd255;

  // Datapath step codes
  typedef enum logic [4:0] {
    OP_IDLE, OP_PREP, OP_PTSMUL, OP_PTS, OP_RDIV, OP_SETPT, OP_FFMUL, OP_FF,
    OP_RD2, OP_DMUL, OP_DCHK, OP_DDIV, OP_IMUL, OP_ISUM, OP_PMUL, OP_PACC,
    OP_IACC, OP_CMD, OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;       // input item taken this cycle
    logic div_start;  // launch the shared divider
    logic load_out;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic need_ramp;
    logic slope_ok;
    logic div_done;
  } status_t;

  // Arithmetic shift right rounding toward zero
  function automatic logic signed [PROD_W-1:0] shr_tz(input logic signed [PROD_W-1:0] x,
                                                      input int s);
    logic signed [PROD_W-1:0] nx;
    nx = -x;
    if (x[PROD_W-1]) begin
      shr_tz = -(nx >>> s);
    end else begin
      shr_tz = x >>> s;
    end
  endfunction

endpackage

>>> rtl/cpid_div.sv
// Serial restoring divider, one quotient bit per cycle, sign applied at the end.
module cpid_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [cpid_pkg::DIV_N_W-1:0]        dividend_i,
  input  logic [cpid_pkg::DIV_D_W-1:0]        divisor_i,
  input  logic                                neg_i,
  output logic                                done_o,
  output logic signed [cpid_pkg::DIV_N_W:0]   quot_o
);

  localparam int NW = cpid_pkg::DIV_N_W;
  localparam int DW = cpid_pkg::DIV_D_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW:0]   rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] dvs_q;
  logic          neg_q;
  logic          done_q;
  logic [DW:0]   rem_sh;
  logic          fits;
  logic [NW:0]   quo_ext;

  // One shift-and-subtract step
  assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign quo_ext = {1'b0, quo_q};
  assign quot_o  = neg_q ? -$signed(quo_ext) : $signed(quo_ext);
  assign done_o  = done_q;

endmodule

>>> rtl/cpid_dp.sv
// Datapath: registers, history memory, shared multiplier and divider, PID arithmetic.
module cpid_dp #(
  parameter int HISTORY_DEPTH      = cpid_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_RAMP_POINTS    = cpid_pkg::DEF_MAX_RAMP_POINTS,
  parameter int TEMP_FRACTION_BITS = cpid_pkg::DEF_TEMP_FRAC
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cpid_pkg::cmd_t                    cmd_i,
  output cpid_pkg::status_t                 status_o,
  input  logic                              cfg_we_i,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [79:0]                       in_data_i,
  input  logic                              in_restart_i,
  output logic [23:0]                       out_data_o,
  output logic [1:0]                        out_user_o
);

  localparam int D    = HISTORY_DEPTH;
  localparam int HW   = $clog2(D);
  localparam int FW   = $clog2(D + 1);
  localparam int RLW  = $clog2(MAX_RAMP_POINTS + 1);
  localparam int SH   = TEMP_FRACTION_BITS + cpid_pkg::GAIN_FRAC;
  localparam int PW   = cpid_pkg::PROD_W;
  localparam int TW   = cpid_pkg::TIME_W;
  localparam logic [15:0] LAST_TGT_RST = 16'((999 << TEMP_FRACTION_BITS) / 10);
  localparam logic signed [PW-1:0] ROUND_HALF = 60'sd1 <<< (SH - 1);

  // Configuration registers
  logic [15:0]        kp_q, ki_q, kff_q, trig_q, ppd_q;
  logic [17:0]        kd_q;
  logic signed [15:0] aoff_q;
  logic [7:0]         step_q;

  // Latched input item
  logic [TW-1:0]      now_q;
  logic signed [15:0] chip_q, amb_q, tgt_q;
  logic               restart_q;

  // Regulator state
  logic signed [15:0] sp_q, last_tgt_q, ramp_pt_q;
  logic [RLW-1:0]     ramp_left_q;
  logic [TW-1:0]      ramp_time_q, prev_q;
  logic signed [16:0] ramp_inc_q;
  logic [FW-1:0]      fill_q;
  logic [HW-1:0]      head_q;
  logic signed [39:0] integ_q;
  logic               first_q;

  // Per-item work registers
  logic [16:0]        err_q;
  logic               in_ramp_q;
  logic [RLW-1:0]     pts_q;
  logic signed [PW-1:0] prod_q, acc_q;
  logic signed [23:0] power_q;
  logic [TW-1:0]      ft_q, lt_q;
  logic signed [15:0] fc_q, lc_q;
  logic signed [TW-1:0] dt_q;
  logic signed [36:0] slope_q;
  logic signed [39:0] trial_q;
  logic [7:0]         pwm_q;
  logic               clamp_q;

  // Output register
  logic [7:0]         out_pwm_q;
  logic [15:0]        out_sp_q;
  logic               out_ramp_q, out_clamp_q;

  // History memory
  logic [TW-1:0]      hist_time [D];
  logic [15:0]        hist_temp [D];

  // Combinational helpers
  logic signed [cpid_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cpid_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0] prod_c;
  logic signed [16:0] e_c, dtemp_c, diff_tc;
  logic signed [17:0] ffd_c;
  logic signed [TW-1:0] dti_c;
  logic [PW-1:0]      pts_raw;
  logic [RLW-1:0]     pts_c;
  logic               need_c;
  logic [cpid_pkg::DIV_N_W-1:0] div_n;
  logic [cpid_pkg::DIV_D_W-1:0] div_d;
  logic               div_neg;
  logic               div_done;
  logic signed [cpid_pkg::DIV_N_W:0] div_q;
  logic signed [PW-1:0] prod_mag;
  logic [FW:0]        wsum, lsum;
  logic [HW-1:0]      slot_c, last_c;
  logic               wr_en;
  logic [RLW-1:0]     left_dec;
  logic signed [16:0] inc_c;
  logic signed [PW-1:0] isum_c, cmd_c;

  assign e_c     = {sp_q[15], sp_q} - {chip_q[15], chip_q};
  assign dtemp_c = {lc_q[15], lc_q} - {fc_q[15], fc_q};
  assign diff_tc = {tgt_q[15], tgt_q} - {chip_q[15], chip_q};
  assign ffd_c   = {{2{amb_q[15]}}, amb_q} - {{2{aoff_q[15]}}, aoff_q}
                 - {{2{sp_q[15]}}, sp_q};
  assign dti_c   = $signed(now_q - prev_q);

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      cpid_pkg::OP_PTSMUL: begin
        mul_a = $signed({24'd0, err_q});
        mul_b = $signed({3'd0, ppd_q});
      end
      cpid_pkg::OP_FFMUL: begin
        mul_a = 41'(ffd_c);
        mul_b = $signed({3'd0, kff_q});
      end
      cpid_pkg::OP_DMUL: begin
        mul_a = 41'(dtemp_c);
        mul_b = $signed({1'b0, kd_q});
      end
      cpid_pkg::OP_IMUL: begin
        mul_a = 41'(dti_c);
        mul_b = 19'(e_c);
      end
      cpid_pkg::OP_PMUL: begin
        mul_a = 41'(e_c);
        mul_b = $signed({3'd0, kp_q});
      end
      cpid_pkg::OP_PACC: begin
        mul_a = 41'(trial_q);
        mul_b = $signed({3'd0, ki_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // Ramp point count, saturated
  assign pts_raw = $unsigned(prod_q) >> SH;
  assign pts_c   = (pts_raw > PW'(MAX_RAMP_POINTS)) ? RLW'(MAX_RAMP_POINTS)
                                                      : pts_raw[RLW-1:0];
  assign need_c  = !in_ramp_q && (err_q > {1'b0, trig_q}) && (pts_c != '0);

  // Divider operands: ramp increment or slope term
  assign prod_mag = prod_q[PW-1] ? -prod_q : prod_q;
  always_comb begin
    if (cmd_i.op == cpid_pkg::OP_PTS) begin
      div_n   = cpid_pkg::DIV_N_W'(err_q);
      div_d   = cpid_pkg::DIV_D_W'(pts_c) + 32'd1;
      div_neg = 1'b0;
    end else begin
      div_n   = prod_mag[cpid_pkg::DIV_N_W-1:0];
      div_d   = dt_q;
      div_neg = prod_q[PW-1];
    end
  end

  cpid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .neg_i      (div_neg),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // History slot arithmetic, wrap by compare and subtract
  assign wsum   = (FW+1)'(head_q) + (FW+1)'(fill_q);
  assign slot_c = (wsum >= (FW+1)'(D)) ? HW'(wsum - (FW+1)'(D)) : HW'(wsum);
  assign lsum   = (FW+1)'(head_q) + (FW+1)'(fill_q) - (FW+1)'(1);
  assign last_c = (lsum >= (FW+1)'(D)) ? HW'(lsum - (FW+1)'(D)) : HW'(lsum);
  assign wr_en  = (cmd_i.op == cpid_pkg::OP_SETPT);

  assign left_dec = ramp_left_q - 1'b1;
  assign inc_c    = div_q[16:0];
  assign isum_c   = PW'(integ_q) + prod_q;
  assign cmd_c    = PW'(power_q) + cpid_pkg::shr_tz(-acc_q, SH);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= cpid_pkg::KP_RST;
      ki_q   <= cpid_pkg::KI_RST;
      kd_q   <= cpid_pkg::KD_RST;
      kff_q  <= cpid_pkg::KFF_RST;
      aoff_q <= cpid_pkg::AOFF_RST;
      trig_q <= cpid_pkg::TRIG_RST;
      step_q <= cpid_pkg::STEP_RST;
      ppd_q  <= cpid_pkg::PPD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpid_pkg::REG_KP:   kp_q   <= cfg_data_i[15:0];
        cpid_pkg::REG_KI:   ki_q   <= cfg_data_i[15:0];
        cpid_pkg::REG_KD:   kd_q   <= cfg_data_i;
        cpid_pkg::REG_KFF:  kff_q  <= cfg_data_i[15:0];
        cpid_pkg::REG_AOFF: aoff_q <= cfg_data_i[15:0];
        cpid_pkg::REG_TRIG: trig_q <= cfg_data_i[15:0];
        cpid_pkg::REG_STEP: step_q <= cfg_data_i[7:0];
        cpid_pkg::REG_PPD:  ppd_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Regulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      last_tgt_q  <= LAST_TGT_RST;
      ramp_left_q <= '0;
      ramp_time_q <= '0;
      ramp_pt_q   <= '0;
      ramp_inc_q  <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      integ_q     <= '0;
      first_q     <= 1'b1;
      prev_q      <= '0;
      in_ramp_q   <= 1'b0;
    end else begin
      case (cmd_i.op)
        cpid_pkg::OP_PREP: begin
          // restart first, then target change
          if (restart_q) begin
            ramp_time_q <= '0;
            ramp_pt_q   <= '0;
            ramp_inc_q  <= '0;
            fill_q      <= '0;
            head_q      <= '0;
            integ_q     <= '0;
            first_q     <= 1'b1;
            prev_q      <= '0;
          end
          if (restart_q || (tgt_q != last_tgt_q)) begin
            ramp_left_q <= '0;
            in_ramp_q   <= 1'b0;
          end else begin
            in_ramp_q   <= (ramp_left_q != '0);
          end
          last_tgt_q <= tgt_q;
        end
        cpid_pkg::OP_RDIV: begin
          if (div_done) begin
            ramp_inc_q  <= (tgt_q < chip_q) ? -inc_c : inc_c;
            ramp_left_q <= pts_q;
            ramp_time_q <= now_q;
            ramp_pt_q   <= chip_q + ((tgt_q < chip_q) ? -inc_c[15:0] : inc_c[15:0]);
            in_ramp_q   <= 1'b1;
          end
        end
        cpid_pkg::OP_SETPT: begin
          if (in_ramp_q) begin
            if (now_q >= ramp_time_q) begin
              sp_q        <= ramp_pt_q;
              ramp_left_q <= left_dec;
              if (left_dec != '0) begin
                ramp_pt_q   <= ramp_pt_q + ramp_inc_q[15:0];
                ramp_time_q <= ramp_time_q + TW'(step_q);
              end
            end
          end else begin
            sp_q <= tgt_q;
          end
          if (fill_q < FW'(D)) begin
            fill_q <= fill_q + 1'b1;
          end else begin
            head_q <= (head_q == HW'(D - 1)) ? '0 : head_q + 1'b1;
          end
        end
        cpid_pkg::OP_ISUM: begin
          first_q <= 1'b0;
          prev_q  <= now_q;
        end
        cpid_pkg::OP_CMD: begin
          if (cmd_c <= cpid_pkg::PWM_MAX && !cmd_c[PW-1]) begin
            integ_q <= trial_q;
          end
        end
        default: ;
      endcase
    end
  end

  // History memory write and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_time[(fill_q < FW'(D)) ? slot_c : head_q] <= now_q;
      hist_temp[(fill_q < FW'(D)) ? slot_c : head_q] <= chip_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cpid_pkg::OP_FF) begin
      ft_q <= hist_time[head_q];
      fc_q <= hist_temp[head_q];
    end
    if (cmd_i.op == cpid_pkg::OP_RD2) begin
      lt_q <= hist_time[last_c];
      lc_q <= hist_temp[last_c];
    end
  end

  // Per-item payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_c;
    if (cmd_i.load) begin
      now_q     <= in_data_i[31:0];
      chip_q    <= in_data_i[47:32];
      amb_q     <= in_data_i[63:48];
      tgt_q     <= in_data_i[79:64];
      restart_q <= in_restart_i;
    end
    case (cmd_i.op)
      cpid_pkg::OP_PREP: begin
        err_q   <= diff_tc[16] ? 17'(-diff_tc) : 17'(diff_tc);
        slope_q <= '0;
      end
      cpid_pkg::OP_PTS:  pts_q   <= pts_c;
      cpid_pkg::OP_FF:   power_q <= 24'(cpid_pkg::shr_tz(prod_q + ROUND_HALF, SH));
      cpid_pkg::OP_DMUL: dt_q    <= $signed(lt_q - ft_q);
      cpid_pkg::OP_DDIV: begin
        if (div_done) slope_q <= div_q;
      end
      cpid_pkg::OP_ISUM: begin
        if (first_q) begin
          trial_q <= '0;
        end else if (isum_c > cpid_pkg::INTEG_MAX) begin
          trial_q <= 40'(cpid_pkg::INTEG_MAX);
        end else if (isum_c < cpid_pkg::INTEG_MIN) begin
          trial_q <= 40'(cpid_pkg::INTEG_MIN);
        end else begin
          trial_q <= 40'(isum_c);
        end
      end
      cpid_pkg::OP_PACC: acc_q <= prod_q;
      cpid_pkg::OP_IACC: acc_q <= acc_q + prod_q - PW'(slope_q);
      cpid_pkg::OP_CMD: begin
        if (cmd_c[PW-1]) begin
          pwm_q   <= '0;
          clamp_q <= 1'b1;
        end else if (cmd_c > cpid_pkg::PWM_MAX) begin
          pwm_q   <= 8'hFF;
          clamp_q <= 1'b1;
        end else begin
          pwm_q   <= cmd_c[7:0];
          clamp_q <= 1'b0;
        end
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_pwm_q   <= pwm_q;
      out_sp_q    <= sp_q;
      out_ramp_q  <= in_ramp_q;
      out_clamp_q <= clamp_q;
    end
  end

  assign status_o.need_ramp = need_c;
  assign status_o.slope_ok  = (fill_q > FW'(1)) && !dt_q[TW-1] && (dt_q != '0);
  assign status_o.div_done  = div_done;

  assign out_data_o = {out_sp_q, out_pwm_q};
  assign out_user_o = {out_clamp_q, out_ramp_q};

endmodule

>>> rtl/cpid_ctrl.sv
// Controller: sequences the datapath steps and runs both stream handshakes.
module cpid_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cpid_pkg::status_t status_i,
  output cpid_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_PTSMUL, ST_PTS, ST_RDIV, ST_SETPT, ST_FFMUL, ST_FF,
    ST_RD2, ST_DMUL, ST_DCHK, ST_DDIV, ST_IMUL, ST_ISUM, ST_PMUL, ST_PACC,
    ST_IACC, ST_CMD, ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign load_out   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Step code and control strobes for the datapath
  always_comb begin
    case (state_q)
      ST_IDLE:   cmd_o.op = cpid_pkg::OP_IDLE;
      ST_PREP:   cmd_o.op = cpid_pkg::OP_PREP;
      ST_PTSMUL: cmd_o.op = cpid_pkg::OP_PTSMUL;
      ST_PTS:    cmd_o.op = cpid_pkg::OP_PTS;
      ST_RDIV:   cmd_o.op = cpid_pkg::OP_RDIV;
      ST_SETPT:  cmd_o.op = cpid_pkg::OP_SETPT;
      ST_FFMUL:  cmd_o.op = cpid_pkg::OP_FFMUL;
      ST_FF:     cmd_o.op = cpid_pkg::OP_FF;
      ST_RD2:    cmd_o.op = cpid_pkg::OP_RD2;
      ST_DMUL:   cmd_o.op = cpid_pkg::OP_DMUL;
      ST_DCHK:   cmd_o.op = cpid_pkg::OP_DCHK;
      ST_DDIV:   cmd_o.op = cpid_pkg::OP_DDIV;
      ST_IMUL:   cmd_o.op = cpid_pkg::OP_IMUL;
      ST_ISUM:   cmd_o.op = cpid_pkg::OP_ISUM;
      ST_PMUL:   cmd_o.op = cpid_pkg::OP_PMUL;
      ST_PACC:   cmd_o.op = cpid_pkg::OP_PACC;
      ST_IACC:   cmd_o.op = cpid_pkg::OP_IACC;
      ST_CMD:    cmd_o.op = cpid_pkg::OP_CMD;
      ST_OUT:    cmd_o.op = cpid_pkg::OP_OUT;
      default:   cmd_o.op = cpid_pkg::OP_IDLE;
    endcase
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_start = ((state_q == ST_PTS) && status_i.need_ramp) ||
                      ((state_q == ST_DCHK) && status_i.slope_ok);
    cmd_o.load_out  = load_out;
  end

  // State register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_PREP;
        ST_PREP:   state_q <= ST_PTSMUL;
        ST_PTSMUL: state_q <= ST_PTS;
        ST_PTS:    state_q <= status_i.need_ramp ? ST_RDIV : ST_SETPT;
        ST_RDIV:   if (status_i.div_done) state_q <= ST_SETPT;
        ST_SETPT:  state_q <= ST_FFMUL;
        ST_FFMUL:  state_q <= ST_FF;
        ST_FF:     state_q <= ST_RD2;
        ST_RD2:    state_q <= ST_DMUL;
        ST_DMUL:   state_q <= ST_DCHK;
        ST_DCHK:   state_q <= status_i.slope_ok ? ST_DDIV : ST_IMUL;
        ST_DDIV:   if (status_i.div_done) state_q <= ST_IMUL;
        ST_IMUL:   state_q <= ST_ISUM;
        ST_ISUM:   state_q <= ST_PMUL;
        ST_PMUL:   state_q <= ST_PACC;
        ST_PACC:   state_q <= ST_IACC;
        ST_IACC:   state_q <= ST_CMD;
        ST_CMD:    state_q <= ST_OUT;
        ST_OUT:    if (load_out) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/cooler_pid_with_ramp_and_feedforward.sv
// Top level of the cooler PID regulator with setpoint ramp and feedforward.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: time, chip, ambient, target; tuser: restart
//  m_axis   | out | m_axis_tvalid/tready    | tdata: pwm, setpoint; tuser: ramping, clamped
//  cfg      | in  | cfg_we_i                | cfg_idx_i register index, cfg_data_i value
//
// One item at a time: a new item is taken only after the last result is loaded into the
// output register; each division waits on the serial divider, one quotient bit per cycle.
// The slope division runs once the history holds two ticks with rising time, the
// ramp-increment division only when a new ramp starts.
// Reset is asynchronous, active low; no clearing pass is needed.
// A result waiting on m_axis does not hold up the next item, which stalls only
// at its last step until the output register is free.
module cooler_pid_with_ramp_and_feedforward #(
  parameter int HISTORY_DEPTH      = cpid_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_RAMP_POINTS    = cpid_pkg::DEF_MAX_RAMP_POINTS,
  parameter int TEMP_FRACTION_BITS = cpid_pkg::DEF_TEMP_FRAC
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [79:0]                     s_axis_tdata,  // tick_time, chip, amb, target
  input  logic                            s_axis_tuser,  // restart
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // pwm_command, working_setpoint
  output logic [1:0]                      m_axis_tuser,  // ramping, clamped
  input  logic                            cfg_we_i,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpid_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cpid_pkg::cmd_t    cmd;
  cpid_pkg::status_t status;

  cpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cpid_dp #(
    .HISTORY_DEPTH      (HISTORY_DEPTH),
    .MAX_RAMP_POINTS    (MAX_RAMP_POINTS),
    .TEMP_FRACTION_BITS (TEMP_FRACTION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .in_restart_i (s_axis_tuser),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser)
  );

  // Divider completes only while the sequencer waits on it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> (cmd.op == cpid_pkg::OP_RDIV || cmd.op == cpid_pkg::OP_DDIV))
    else $error("divider finished outside a wait step");

  // No new item is taken while a division is being launched
  a_no_take_on_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !s_axis_tready)
    else $error("input ready during a division");

  // One item in flight: after a take, ready drops
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while busy");

endmodule
